FILE: design/twsa_pkg.sv
// ---------------------------------------------------------------------------
// Twirl warp source address package
// Types, widths and constants shared by the twirl source address pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package twsa_pkg;

    // Field and datapath widths.
    localparam int DIM_W     = 13;
    localparam int CRD_W     = 12;
    localparam int STR_W     = 16;
    localparam int DXY_W     = 14;
    localparam int SQ_W      = 27;
    localparam int RAD_W     = 44;
    localparam int ROOT_W    = 22;
    localparam int SQ_REM_W  = 26;
    localparam int RDIFF_W   = 24;
    localparam int RMAG_W    = 23;
    localparam int P_W       = 39;
    localparam int P_LO_W    = 19;
    localparam int P_HI_W    = 20;
    localparam int C24_W     = 22;
    localparam int N_W       = 61;
    localparam int QUO_W     = 42;
    localparam int PHASE_W   = 32;
    localparam int XY_W      = 34;
    localparam int GAIN_W    = 30;
    localparam int XL_W      = 17;
    localparam int XH_W      = 17;
    localparam int PPH_W     = 48;
    localparam int PPL_W     = 47;
    localparam int SUM_W     = 66;
    localparam int UV_W      = 40;
    localparam int IDX_W     = 3;
    localparam int CFG_W     = 16;

    // Fixed-point constants: one turn over two pi in Q24 and the inverse CORDIC gain in Q30.
    localparam logic [C24_W-1:0]  TURN_C24     = 22'd2670177;
    localparam logic [GAIN_W-1:0] INV_GAIN_Q30 = 30'd652032874;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_WIDTH    = 3'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT   = 3'd1;
    localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd2;
    localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd3;
    localparam logic [IDX_W-1:0] REG_STRENGTH = 3'd4;

    typedef struct packed {
        logic [CRD_W-1:0] out_col;
        logic [CRD_W-1:0] out_row;
    } in_item_t;

    typedef struct packed {
        logic [CRD_W-1:0] src_x;
        logic [CRD_W-1:0] src_y;
        logic             in_range;
    } out_item_t;

    // Data that rides along the chain beside each cell's own working state.
    typedef struct packed {
        logic signed [DXY_W-1:0] dx;
        logic signed [DXY_W-1:0] dy;
        logic                    neg;
    } side_t;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   root;
        logic [RAD_W-1:0]    rad;
        side_t               side;
    } sqrt_stage_t;

    typedef struct packed {
        logic [DIM_W-1:0] rem;
        logic [N_W-1:0]   num;
        logic [QUO_W-1:0] quo;
        side_t            side;
    } div_stage_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [XY_W-1:0] z;
    } cor_stage_t;

    // Arctangent of 2^-i as a fraction of one turn, scaled by 2^32.
    function automatic logic [PHASE_W-1:0] atan_turn(input int idx);
        logic [PHASE_W-1:0] a;
        case (idx)
            0:  a = 32'd536870912;
            1:  a = 32'd316933406;
            2:  a = 32'd167458907;
            3:  a = 32'd85004756;
            4:  a = 32'd42667331;
            5:  a = 32'd21354465;
            6:  a = 32'd10679838;
            7:  a = 32'd5340245;
            8:  a = 32'd2670163;
            9:  a = 32'd1335087;
            10: a = 32'd667544;
            11: a = 32'd333772;
            12: a = 32'd166886;
            13: a = 32'd83443;
            14: a = 32'd41722;
            15: a = 32'd20861;
            16: a = 32'd10430;
            17: a = 32'd5215;
            18: a = 32'd2608;
            19: a = 32'd1304;
            20: a = 32'd652;
            21: a = 32'd326;
            22: a = 32'd163;
            23: a = 32'd81;
            24: a = 32'd41;
            25: a = 32'd20;
            26: a = 32'd10;
            27: a = 32'd5;
            28: a = 32'd3;
            29: a = 32'd1;
            30: a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

FILE: design/twsa_sqrt_cell.sv
// ---------------------------------------------------------------------------
// Square root cell
// One digit of a bit-by-bit integer square root: takes two radicand bits,
// produces one root bit and registers the result for the next cell.
// ---------------------------------------------------------------------------
`default_nettype none

module twsa_sqrt_cell (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire twsa_pkg::sqrt_stage_t in_stage,
    output logic                      out_valid,
    output twsa_pkg::sqrt_stage_t     out_stage
);

    logic                  valid_reg;
    twsa_pkg::sqrt_stage_t stage_reg;
    twsa_pkg::sqrt_stage_t stage_next;
    logic [twsa_pkg::SQ_REM_W-1:0] rem_sh;
    logic [twsa_pkg::SQ_REM_W-1:0] trial;

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
        rem_sh = {in_stage.rem[twsa_pkg::SQ_REM_W-3:0],
                  in_stage.rad[twsa_pkg::RAD_W-1 -: 2]};
        trial  = {2'b00, in_stage.root, 2'b01};
        stage_next      = in_stage;
        stage_next.rad  = {in_stage.rad[twsa_pkg::RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            stage_next.rem  = rem_sh - trial;
            stage_next.root = {in_stage.root[twsa_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            stage_next.rem  = rem_sh;
            stage_next.root = {in_stage.root[twsa_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

`default_nettype wire

FILE: design/twsa_div_cell.sv
// ---------------------------------------------------------------------------
// Divider cell
// One step of a restoring long division by the smaller image dimension:
// one numerator bit in, one quotient bit out, registered.
// ---------------------------------------------------------------------------
`default_nettype none

module twsa_div_cell (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic [twsa_pkg::DIM_W-1:0] divisor,
    input  wire logic                       in_valid,
    input  wire twsa_pkg::div_stage_t       in_stage,
    output logic                            out_valid,
    output twsa_pkg::div_stage_t            out_stage
);

    logic                 valid_reg;
    twsa_pkg::div_stage_t stage_reg;
    twsa_pkg::div_stage_t stage_next;
    logic [twsa_pkg::DIM_W:0] part;
    logic [twsa_pkg::DIM_W:0] diff;
    logic                     ge;

    // Shift in the next numerator bit and subtract the divisor when it fits.
    always_comb begin
        part = {in_stage.rem, in_stage.num[twsa_pkg::N_W-1]};
        diff = part - {1'b0, divisor};
        ge   = (part >= {1'b0, divisor});
        stage_next     = in_stage;
        stage_next.num = {in_stage.num[twsa_pkg::N_W-2:0], 1'b0};
        stage_next.quo = {in_stage.quo[twsa_pkg::QUO_W-2:0], ge};
        stage_next.rem = ge ? diff[twsa_pkg::DIM_W-1:0] : part[twsa_pkg::DIM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

`default_nettype wire

FILE: design/twsa_cordic_cell.sv
// ---------------------------------------------------------------------------
// CORDIC rotation cell
// One micro-rotation of the vector towards a residual angle of zero,
// using a fixed shift and arctangent constant for its place in the chain.
// ---------------------------------------------------------------------------
`default_nettype none

module twsa_cordic_cell #(
    parameter int IDX = 0
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire twsa_pkg::cor_stage_t in_stage,
    output logic                      out_valid,
    output twsa_pkg::cor_stage_t      out_stage
);

    localparam logic signed [twsa_pkg::XY_W-1:0] Atan =
        {2'b00, twsa_pkg::atan_turn(IDX)};

    logic                 valid_reg;
    twsa_pkg::cor_stage_t stage_reg;
    twsa_pkg::cor_stage_t stage_next;
    logic signed [twsa_pkg::XY_W-1:0] xs;
    logic signed [twsa_pkg::XY_W-1:0] ys;

    // Rotate by plus or minus the stage angle, by the sign of the residual.
    always_comb begin
        xs = in_stage.x >>> IDX;
        ys = in_stage.y >>> IDX;
        if (!in_stage.z[twsa_pkg::XY_W-1]) begin
            stage_next.x = in_stage.x - ys;
            stage_next.y = in_stage.y + xs;
            stage_next.z = in_stage.z - Atan;
        end else begin
            stage_next.x = in_stage.x + ys;
            stage_next.y = in_stage.y - xs;
            stage_next.z = in_stage.z + Atan;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

`default_nettype wire

FILE: design/twirl_warp_source_address_top.sv
// ---------------------------------------------------------------------------
// Twirl warp source address generator
// Maps each output pixel position to its source position under a twirl.
// ---------------------------------------------------------------------------
// Usage:
// Output pixel positions arrive on the s_ channel; one source address per
// position leaves on the m_ channel, in the same order. The cfg_ channel
// writes the image size, the twirl centre and the strength; it is always
// ready and should be written only while no transfer is in flight.
// An item passes through these stages in order from an input transfer to the
// result on the output register: three set-up stages, 22 square root cells,
// four multiply stages, 61 divider cells, a phase fold, the CORDIC cells, two
// gain stages and the output register.
// Throughput is one position per clock; every cell of the chain holds its
// own item, so one transfer may be taken in every cycle.
// Reset clears all valid flags and loads the registers with 640 by 480,
// centre 320, 240 and zero strength. While the receiver stalls, the chain
// keeps filling until an item reaches the last stage behind the held
// output, then the whole chain and s_ready hold.
// ---------------------------------------------------------------------------
`default_nettype none

module twirl_warp_source_address_top #(
    parameter int MAX_DIM       = 4096,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire twsa_pkg::in_item_t         s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output twsa_pkg::out_item_t             m_data,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [twsa_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [twsa_pkg::CFG_W-1:0] cfg_data
);

    localparam int DimCapInt = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
    localparam logic [twsa_pkg::DIM_W-1:0] DimCap = twsa_pkg::DIM_W'(DimCapInt);
    localparam int NCor = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

    // Configuration registers.
    logic [twsa_pkg::DIM_W-1:0] width_reg;
    logic [twsa_pkg::DIM_W-1:0] height_reg;
    logic [twsa_pkg::DIM_W-1:0] cx_reg;
    logic [twsa_pkg::DIM_W-1:0] cy_reg;
    logic signed [twsa_pkg::STR_W-1:0] str_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 13'd640;
            height_reg <= 13'd480;
            cx_reg     <= 13'd320;
            cy_reg     <= 13'd240;
            str_reg    <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                twsa_pkg::REG_WIDTH:    width_reg  <= cfg_data[twsa_pkg::DIM_W-1:0];
                twsa_pkg::REG_HEIGHT:   height_reg <= cfg_data[twsa_pkg::DIM_W-1:0];
                twsa_pkg::REG_CENTER_X: cx_reg     <= cfg_data[twsa_pkg::DIM_W-1:0];
                twsa_pkg::REG_CENTER_Y: cy_reg     <= cfg_data[twsa_pkg::DIM_W-1:0];
                twsa_pkg::REG_STRENGTH: str_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective dimensions: zero reads as one, large values are capped.
    logic [twsa_pkg::DIM_W-1:0] w_eff;
    logic [twsa_pkg::DIM_W-1:0] h_eff;
    logic [twsa_pkg::DIM_W-1:0] m_dim;
    logic [twsa_pkg::STR_W-1:0] smag;

    always_comb begin
        w_eff = (width_reg == '0) ? 13'd1 : ((width_reg > DimCap) ? DimCap : width_reg);
        h_eff = (height_reg == '0) ? 13'd1 : ((height_reg > DimCap) ? DimCap : height_reg);
        m_dim = (w_eff < h_eff) ? w_eff : h_eff;
        smag  = str_reg[twsa_pkg::STR_W-1] ? twsa_pkg::STR_W'(-str_reg) : str_reg;
    end

    // Chain advance: holds only when the last stage has an item the output cannot take.
    logic out_load;
    logic en;
    logic g2_valid_reg;
    logic m_valid_reg;

    assign out_load = !m_valid_reg || m_ready;
    assign en       = out_load || !g2_valid_reg;
    assign s_ready  = en;

    // Input stage: offset from the twirl centre.
    logic s0_valid_reg;
    twsa_pkg::side_t s0_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (en) begin
            s0_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_side_reg <= '{
                dx:  $signed({2'b00, s_data.out_col}) - $signed({1'b0, cx_reg}),
                dy:  $signed({2'b00, s_data.out_row}) - $signed({1'b0, cy_reg}),
                neg: 1'b0
            };
        end
    end

    // Squares of the offsets, then their sum.
    logic s1_valid_reg;
    twsa_pkg::side_t s1_side_reg;
    logic [twsa_pkg::SQ_W-2:0] sqx_reg;
    logic [twsa_pkg::SQ_W-2:0] sqy_reg;
    logic s2_valid_reg;
    twsa_pkg::side_t s2_side_reg;
    logic [twsa_pkg::SQ_W-1:0] r2_reg;
    logic signed [2*twsa_pkg::DXY_W-1:0] sqx_full;
    logic signed [2*twsa_pkg::DXY_W-1:0] sqy_full;

    assign sqx_full = s0_side_reg.dx * s0_side_reg.dx;
    assign sqy_full = s0_side_reg.dy * s0_side_reg.dy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_side_reg <= s0_side_reg;
            sqx_reg     <= sqx_full[twsa_pkg::SQ_W-2:0];
            sqy_reg     <= sqy_full[twsa_pkg::SQ_W-2:0];
            s2_side_reg <= s1_side_reg;
            r2_reg      <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
        end
    end

    // Square root chain on the radius squared in Q16, giving the radius in Q8.
    logic                  sq_valid [0:twsa_pkg::ROOT_W];
    twsa_pkg::sqrt_stage_t sq_stage [0:twsa_pkg::ROOT_W];

    always_comb begin
        sq_valid[0]      = s2_valid_reg;
        sq_stage[0].rem  = '0;
        sq_stage[0].root = '0;
        sq_stage[0].rad  = {1'b0, r2_reg, 16'd0};
        sq_stage[0].side = s2_side_reg;
    end

    for (genvar k = 0; k < twsa_pkg::ROOT_W; k++) begin : g_sqrt
        twsa_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sq_valid[k]),
            .in_stage  (sq_stage[k]),
            .out_valid (sq_valid[k+1]),
            .out_stage (sq_stage[k+1])
        );
    end

    // Twirl amount: strength times the radius offset from the smaller dimension.
    logic sa_valid_reg;
    twsa_pkg::side_t sa_side_reg;
    logic [twsa_pkg::RMAG_W-1:0] rmag_reg;
    logic signed [twsa_pkg::RDIFF_W-1:0] rdiff;
    logic [twsa_pkg::RDIFF_W-1:0] rdiff_abs;

    always_comb begin
        rdiff = $signed({2'b00, sq_stage[twsa_pkg::ROOT_W].root})
              - $signed({3'b000, m_dim, 8'd0});
        rdiff_abs = rdiff[twsa_pkg::RDIFF_W-1] ? twsa_pkg::RDIFF_W'(-rdiff) : rdiff;
    end

    logic sb_valid_reg;
    twsa_pkg::side_t sb_side_reg;
    logic [twsa_pkg::P_W-1:0] p_reg;
    logic sc_valid_reg;
    twsa_pkg::side_t sc_side_reg;
    logic [twsa_pkg::P_HI_W+twsa_pkg::C24_W-1:0] pch_reg;
    logic [twsa_pkg::P_LO_W+twsa_pkg::C24_W-1:0] pcl_reg;
    logic sd_valid_reg;
    twsa_pkg::side_t sd_side_reg;
    logic [twsa_pkg::N_W-1:0] n_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sa_valid_reg <= 1'b0;
            sb_valid_reg <= 1'b0;
            sc_valid_reg <= 1'b0;
            sd_valid_reg <= 1'b0;
        end else if (en) begin
            sa_valid_reg <= sq_valid[twsa_pkg::ROOT_W];
            sb_valid_reg <= sa_valid_reg;
            sc_valid_reg <= sb_valid_reg;
            sd_valid_reg <= sc_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sa_side_reg <= '{
                dx:  sq_stage[twsa_pkg::ROOT_W].side.dx,
                dy:  sq_stage[twsa_pkg::ROOT_W].side.dy,
                neg: str_reg[twsa_pkg::STR_W-1] != rdiff[twsa_pkg::RDIFF_W-1]
            };
            rmag_reg        <= rdiff_abs[twsa_pkg::RMAG_W-1:0];
            sb_side_reg     <= sa_side_reg;
            p_reg           <= twsa_pkg::P_W'(smag * rmag_reg);
            sc_side_reg     <= sb_side_reg;
            pch_reg         <= p_reg[twsa_pkg::P_W-1 -: twsa_pkg::P_HI_W] * twsa_pkg::TURN_C24;
            pcl_reg         <= p_reg[twsa_pkg::P_LO_W-1:0] * twsa_pkg::TURN_C24;
            sd_side_reg     <= sc_side_reg;
            n_reg           <= twsa_pkg::N_W'({pch_reg, {twsa_pkg::P_LO_W{1'b0}}})
                             + twsa_pkg::N_W'(pcl_reg);
        end
    end

    // Long division by the smaller dimension, one quotient bit per cell.
    logic                 dv_valid [0:twsa_pkg::N_W];
    twsa_pkg::div_stage_t dv_stage [0:twsa_pkg::N_W];

    always_comb begin
        dv_valid[0]      = sd_valid_reg;
        dv_stage[0].rem  = '0;
        dv_stage[0].num  = n_reg;
        dv_stage[0].quo  = '0;
        dv_stage[0].side = sd_side_reg;
    end

    for (genvar k = 0; k < twsa_pkg::N_W; k++) begin : g_div
        twsa_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .divisor   (m_dim),
            .in_valid  (dv_valid[k]),
            .in_stage  (dv_stage[k]),
            .out_valid (dv_valid[k+1]),
            .out_stage (dv_stage[k+1])
        );
    end

    // Phase in turns, folded into the right half-plane for the CORDIC.
    logic [twsa_pkg::PHASE_W-1:0] q_ph;
    logic [twsa_pkg::PHASE_W-1:0] phase;
    logic [twsa_pkg::PHASE_W-1:0] phase_f;
    logic signed [twsa_pkg::XY_W-1:0] x0;
    logic signed [twsa_pkg::XY_W-1:0] y0;
    logic                 ph_valid_reg;
    twsa_pkg::cor_stage_t ph_stage_reg;
    twsa_pkg::cor_stage_t ph_stage_next;
    twsa_pkg::side_t      dv_side;

    always_comb begin
        dv_side = dv_stage[twsa_pkg::N_W].side;
        q_ph    = dv_stage[twsa_pkg::N_W].quo[twsa_pkg::QUO_W-1 -: twsa_pkg::PHASE_W];
        phase   = dv_side.neg ? (32'd0 - q_ph) : q_ph;
        x0      = {{4{dv_side.dx[twsa_pkg::DXY_W-1]}}, dv_side.dx, 16'd0};
        y0      = {{4{dv_side.dy[twsa_pkg::DXY_W-1]}}, dv_side.dy, 16'd0};
        if (phase[31] != phase[30]) begin
            phase_f         = {~phase[31], phase[30:0]};
            ph_stage_next.x = -x0;
            ph_stage_next.y = -y0;
        end else begin
            phase_f         = phase;
            ph_stage_next.x = x0;
            ph_stage_next.y = y0;
        end
        ph_stage_next.z = {{2{phase_f[31]}}, phase_f};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_valid_reg <= 1'b0;
        end else if (en) begin
            ph_valid_reg <= dv_valid[twsa_pkg::N_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ph_stage_reg <= ph_stage_next;
        end
    end

    // CORDIC rotation chain.
    logic                 cr_valid [0:NCor];
    twsa_pkg::cor_stage_t cr_stage [0:NCor];

    assign cr_valid[0] = ph_valid_reg;
    assign cr_stage[0] = ph_stage_reg;

    for (genvar k = 0; k < NCor; k++) begin : g_cordic
        twsa_cordic_cell #(
            .IDX (k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (cr_valid[k]),
            .in_stage  (cr_stage[k]),
            .out_valid (cr_valid[k+1]),
            .out_stage (cr_stage[k+1])
        );
    end

    // Gain correction as split partial products, then the centre is added back.
    logic g1_valid_reg;
    logic signed [twsa_pkg::PPH_W-1:0] pxh_reg;
    logic signed [twsa_pkg::PPH_W-1:0] pyh_reg;
    logic [twsa_pkg::PPL_W-1:0] pxl_reg;
    logic [twsa_pkg::PPL_W-1:0] pyl_reg;
    logic signed [twsa_pkg::GAIN_W:0] gain_s;
    logic signed [twsa_pkg::XY_W-1:0] xc;
    logic signed [twsa_pkg::XY_W-1:0] yc;
    logic signed [twsa_pkg::PPH_W-1:0] pxh_full;
    logic signed [twsa_pkg::PPH_W-1:0] pyh_full;

    always_comb begin
        gain_s   = $signed({1'b0, twsa_pkg::INV_GAIN_Q30});
        xc       = cr_stage[NCor].x;
        yc       = cr_stage[NCor].y;
        pxh_full = $signed(xc[twsa_pkg::XY_W-1 -: twsa_pkg::XH_W]) * gain_s;
        pyh_full = $signed(yc[twsa_pkg::XY_W-1 -: twsa_pkg::XH_W]) * gain_s;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g1_valid_reg <= 1'b0;
            g2_valid_reg <= 1'b0;
        end else if (en) begin
            g1_valid_reg <= cr_valid[NCor];
            g2_valid_reg <= g1_valid_reg;
        end
    end

    logic signed [twsa_pkg::SUM_W-1:0] sum_x;
    logic signed [twsa_pkg::SUM_W-1:0] sum_y;
    logic signed [twsa_pkg::UV_W-1:0]  u_next;
    logic signed [twsa_pkg::UV_W-1:0]  v_next;
    logic signed [twsa_pkg::UV_W-1:0]  u_reg;
    logic signed [twsa_pkg::UV_W-1:0]  v_reg;

    always_comb begin
        sum_x  = ($signed(twsa_pkg::SUM_W'(pxh_reg)) <<< twsa_pkg::XL_W)
               + $signed({{(twsa_pkg::SUM_W-twsa_pkg::PPL_W){1'b0}}, pxl_reg});
        sum_y  = ($signed(twsa_pkg::SUM_W'(pyh_reg)) <<< twsa_pkg::XL_W)
               + $signed({{(twsa_pkg::SUM_W-twsa_pkg::PPL_W){1'b0}}, pyl_reg});
        u_next = $signed({11'd0, cx_reg, 16'd0}) + twsa_pkg::UV_W'(sum_x >>> 30);
        v_next = $signed({11'd0, cy_reg, 16'd0}) + twsa_pkg::UV_W'(sum_y >>> 30);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pxh_reg <= pxh_full;
            pyh_reg <= pyh_full;
            pxl_reg <= xc[twsa_pkg::XL_W-1:0] * twsa_pkg::INV_GAIN_Q30;
            pyl_reg <= yc[twsa_pkg::XL_W-1:0] * twsa_pkg::INV_GAIN_Q30;
            u_reg   <= u_next;
            v_reg   <= v_next;
        end
    end

    // Range check, round half up and clamp into the image.
    twsa_pkg::out_item_t res;
    logic [twsa_pkg::UV_W-1:0] u_lim;
    logic [twsa_pkg::UV_W-1:0] v_lim;
    logic [twsa_pkg::UV_W-1:0] u_rnd;
    logic [twsa_pkg::UV_W-1:0] v_rnd;
    logic [twsa_pkg::DIM_W-1:0] w_last;
    logic [twsa_pkg::DIM_W-1:0] h_last;
    logic inside_img;

    always_comb begin
        u_lim  = {11'd0, w_eff, 16'd0};
        v_lim  = {11'd0, h_eff, 16'd0};
        u_rnd  = $unsigned(u_reg) + 40'd32768;
        v_rnd  = $unsigned(v_reg) + 40'd32768;
        w_last = w_eff - 13'd1;
        h_last = h_eff - 13'd1;
        inside_img = !u_reg[twsa_pkg::UV_W-1] && !v_reg[twsa_pkg::UV_W-1]
                  && ($unsigned(u_reg) < u_lim) && ($unsigned(v_reg) < v_lim);
        res = '0;
        if (inside_img) begin
            res.in_range = 1'b1;
            res.src_x = (u_rnd[twsa_pkg::UV_W-1:16] > {11'd0, w_last})
                      ? w_last[twsa_pkg::CRD_W-1:0] : u_rnd[16 +: twsa_pkg::CRD_W];
            res.src_y = (v_rnd[twsa_pkg::UV_W-1:16] > {11'd0, h_last})
                      ? h_last[twsa_pkg::CRD_W-1:0] : v_rnd[16 +: twsa_pkg::CRD_W];
        end
    end

    // Output register.
    twsa_pkg::out_item_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= g2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

FILE: design/twsa_checker.sv
// ---------------------------------------------------------------------------
// Twirl warp source address checker
// Port-level checks on the result and configuration channels, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module twsa_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire twsa_pkg::out_item_t m_data,
    input wire logic                cfg_ready
);

    // No result is offered in the cycle after reset.
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result offered straight after reset");

    // A black pixel always carries zero coordinates.
    a_black_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.in_range |-> m_data.src_x == '0 && m_data.src_y == '0)
        else $error("out-of-range result with nonzero coordinates");

    // A stalled result holds until its transfer.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // The configuration port never pushes back.
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn) cfg_ready)
        else $error("configuration port not ready");

endmodule

bind twirl_warp_source_address_top twsa_checker u_twsa_checker (.*);

`default_nettype wire
